[hw/rtl/dnsarl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS answer record locator package
// Record kinds, status codes and walker states.
// ----------------------------------------------------------------------------
package dnsarl_pkg;

  localparam logic [1:0] KIND_A      = 2'd0;
  localparam logic [1:0] KIND_AAAA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD      = 2'd1;
  localparam logic [1:0] ST_OVERSIZE = 2'd2;

  localparam int HeaderBytes = 12;
  localparam int MaxRecords  = 31;
  localparam logic [15:0] TYPE_A    = 16'd1;
  localparam logic [15:0] TYPE_AAAA = 16'd28;
  localparam logic [15:0] CLASS_IN  = 16'd1;

  typedef enum logic [10:0] {
    S_LOAD  = 11'b00000000001,
    S_RD    = 11'b00000000010,
    S_HDR   = 11'b00000000100,
    S_NAME  = 11'b00000001000,
    S_PTR   = 11'b00000010000,
    S_QEND  = 11'b00000100000,
    S_FIX   = 11'b00001000000,
    S_ADDR  = 11'b00010000000,
    S_EMIT  = 11'b00100000000,
    S_STAT  = 11'b01000000000,
    S_WAIT  = 11'b10000000000
  } state_t;

endpackage

[hw/rtl/dns_answer_record_locator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS answer record locator
// Stores a DNS response and reports its A/AAAA answers and a final status.
// ----------------------------------------------------------------------------
// Bytes load one per cycle while ready_in is high into the packet memory. After
// the last byte the walker reads the stored packet a byte at a time (address
// in S_RD, registered memory read, use after S_WAIT); compression pointers can
// send the walk back over earlier bytes. Input is held off until the status
// beat is taken. Each result beat waits in the output register until taken,
// and the walk stalls while that register is still full.
module dns_answer_record_locator
  import dnsarl_pkg::*;
#(
  parameter int PACKET_BYTES      = 512,
  parameter int MAX_POINTER_JUMPS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  output logic        ready_in,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        valid_out,
  input  logic        ready_out,
  output logic [1:0]  record_kind,
  output logic [8:0]  data_offset,
  output logic [8:0]  ttl_start,
  output logic [63:0] address_high,
  output logic [63:0] address_low,
  output logic [1:0]  status,
  output logic        run_last
);

  localparam int AW = $clog2(PACKET_BYTES);
  localparam int CW = $clog2(PACKET_BYTES + 1);
  localparam int PW = 18;
  localparam int JW = $clog2(MAX_POINTER_JUMPS + 2);

  logic [7:0]    mem [PACKET_BYTES];
  logic [7:0]    rdata;
  logic [AW-1:0] raddr;
  logic          rd_en;

  state_t        state, ret;
  logic [CW-1:0] byte_count;
  logic          overflow_flag;
  logic [PW-1:0] size;
  logic [PW-1:0] rp;        // byte being read
  logic [PW-1:0] parse_offset;
  logic [PW-1:0] pos;
  logic [4:0]    hcnt;      // byte index within a fixed field group
  logic [15:0]   qd, an, rec_cnt;
  logic          in_answers;
  logic          jumped;
  logic [JW-1:0] jump_counter;
  logic [PW-1:0] used;
  logic [5:0]    plen;
  logic [15:0]   r_type, r_cls, r_len;
  logic [127:0]  addr;
  logic [5:0]    nrec;
  logic [1:0]    kind;
  logic [1:0]    st_code;
  logic [PW-1:0] name_end;
  logic          out_load;

  assign ready_in = (state == S_LOAD) && !valid_out;
  assign name_end = parse_offset + used + (jumped ? PW'(0) : PW'(1));
  assign out_load = (state == S_EMIT || state == S_STAT) && (!valid_out || ready_out);

  always_ff @(posedge clk) begin
    if (state == S_LOAD && valid_in && ready_in && !(byte_count == CW'(PACKET_BYTES)))
      mem[byte_count[AW-1:0]] <= data_byte;
    if (rd_en) rdata <= mem[raddr];
  end

  assign rd_en = (state == S_RD);
  assign raddr = rp[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      ret           <= S_LOAD;
      byte_count    <= '0;
      overflow_flag <= 1'b0;
      valid_out     <= 1'b0;
    end else begin
      if (out_load) valid_out <= 1'b1;
      else if (ready_out) valid_out <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (valid_in && ready_in) begin
            if (last_byte) begin
              byte_count    <= '0;
              overflow_flag <= 1'b0;
            end else if (byte_count == CW'(PACKET_BYTES)) begin
              overflow_flag <= 1'b1;
            end else begin
              byte_count <= byte_count + 1'b1;
            end
            if (last_byte) begin
              size  <= PW'(byte_count) +
                       ((byte_count == CW'(PACKET_BYTES)) ? PW'(0) : PW'(1));
              nrec  <= '0;
              if (overflow_flag || byte_count == CW'(PACKET_BYTES)) begin
                st_code <= ST_OVERSIZE;
                state   <= S_STAT;
              end else if (byte_count < CW'(HeaderBytes - 1)) begin
                st_code <= ST_BAD;
                state   <= S_STAT;
              end else begin
                st_code <= ST_OK;
                rp      <= PW'(4);
                hcnt    <= '0;
                ret     <= S_HDR;
                state   <= S_RD;
              end
            end
          end
        end
        S_RD: state <= S_WAIT;
        S_WAIT: state <= ret;
        S_HDR: begin
          rp <= rp + 1'b1;
          unique case (hcnt[1:0])
            2'd0: qd[15:8] <= rdata;
            2'd1: qd[7:0]  <= rdata;
            2'd2: an[15:8] <= rdata;
            default: an[7:0] <= rdata;
          endcase
          if (hcnt[1:0] == 2'd3) begin
            parse_offset <= PW'(HeaderBytes);
            in_answers   <= 1'b0;
            rec_cnt      <= '0;
            state        <= S_QEND;
            hcnt         <= '0;
          end else begin
            hcnt  <= hcnt + 1'b1;
            state <= S_RD;
          end
        end
        S_QEND: begin
          // switch to answers, start next name or finish
          if (!in_answers && qd == rec_cnt) begin
            in_answers <= 1'b1;
            rec_cnt    <= '0;
          end else if (in_answers && an == rec_cnt) begin
            state <= S_STAT;
          end else begin
            pos          <= parse_offset;
            rp           <= parse_offset;
            used         <= '0;
            jumped       <= 1'b0;
            jump_counter <= '0;
            if (parse_offset >= size) begin
              st_code <= ST_BAD; state <= S_STAT;
            end else begin
              ret <= S_NAME; state <= S_RD;
            end
          end
        end
        S_NAME: begin
          if (rdata[7:6] == 2'b11) begin
            plen <= rdata[5:0];
            if (pos + 1'b1 >= size) begin
              st_code <= ST_BAD; state <= S_STAT;
            end else begin
              rp <= pos + 1'b1; ret <= S_PTR; state <= S_RD;
            end
          end else if (rdata[7:6] != 2'b00) begin
            st_code <= ST_BAD; state <= S_STAT;
          end else if (rdata == 8'd0) begin
            hcnt  <= '0;
            if (in_answers) begin
              if (name_end + PW'(10) > size) begin
                st_code <= ST_BAD; state <= S_STAT;
              end else begin
                parse_offset <= name_end;
                rp  <= name_end;
                ret <= S_FIX; state <= S_RD;
              end
            end else begin
              if (name_end + PW'(4) > size) begin
                st_code <= ST_BAD; state <= S_STAT;
              end else begin
                parse_offset <= name_end + PW'(4);
                rec_cnt <= rec_cnt + 1'b1;
                state   <= S_QEND;
              end
            end
          end else begin
            if (pos + 1'b1 + PW'(rdata) > size) begin
              st_code <= ST_BAD; state <= S_STAT;
            end else begin
              if (!jumped) used <= used + PW'(rdata) + 1'b1;
              pos <= pos + 1'b1 + PW'(rdata);
              rp  <= pos + 1'b1 + PW'(rdata);
              if (pos + 1'b1 + PW'(rdata) >= size) begin
                st_code <= ST_BAD; state <= S_STAT;
              end else begin
                ret <= S_NAME; state <= S_RD;
              end
            end
          end
        end
        S_PTR: begin
          if (PW'({plen, rdata}) >= size) begin
            st_code <= ST_BAD; state <= S_STAT;
          end else if (jump_counter == JW'(MAX_POINTER_JUMPS)) begin
            st_code <= ST_BAD; state <= S_STAT;
          end else begin
            if (!jumped) used <= used + PW'(2);
            jumped       <= 1'b1;
            jump_counter <= jump_counter + 1'b1;
            pos <= PW'({plen, rdata});
            rp  <= PW'({plen, rdata});
            ret <= S_NAME; state <= S_RD;
          end
        end
        S_FIX: begin
          rp <= rp + 1'b1;
          unique case (hcnt[3:0])
            4'd0: r_type[15:8] <= rdata;
            4'd1: r_type[7:0]  <= rdata;
            4'd2: r_cls[15:8]  <= rdata;
            4'd3: r_cls[7:0]   <= rdata;
            4'd8: r_len[15:8]  <= rdata;
            4'd9: r_len[7:0]   <= rdata;
            default: ;
          endcase
          if (hcnt[3:0] == 4'd9) begin
            hcnt <= '0;
            if (parse_offset + PW'(10) + PW'({r_len[15:8], rdata}) > size) begin
              st_code <= ST_BAD; state <= S_STAT;
            end else if (r_cls == CLASS_IN && nrec < 6'(MaxRecords) &&
                         ((r_type == TYPE_A && {r_len[15:8], rdata} == 16'd4) ||
                          (r_type == TYPE_AAAA && {r_len[15:8], rdata} == 16'd16))) begin
              kind  <= (r_type == TYPE_A) ? KIND_A : KIND_AAAA;
              addr  <= '0;
              ret   <= S_ADDR; state <= S_RD;
            end else begin
              parse_offset <= parse_offset + PW'(10) + PW'({r_len[15:8], rdata});
              rec_cnt <= rec_cnt + 1'b1;
              state   <= S_QEND;
            end
          end else begin
            hcnt  <= hcnt + 1'b1;
            state <= S_RD;
          end
        end
        S_ADDR: begin
          hcnt <= hcnt + 1'b1;
          rp   <= rp + 1'b1;
          addr <= {addr[119:0], rdata};
          if (hcnt == ((kind == KIND_A) ? 5'd3 : 5'd15)) state <= S_EMIT;
          else state <= S_RD;
        end
        S_EMIT: begin
          if (out_load) begin
            record_kind  <= kind;
            data_offset  <= 9'(parse_offset + PW'(10));
            ttl_start    <= 9'(parse_offset + PW'(4));
            address_high <= addr[127:64];
            address_low  <= addr[63:0];
            status       <= ST_OK;
            run_last     <= 1'b0;
            nrec         <= nrec + 1'b1;
            parse_offset <= parse_offset + PW'(10) + PW'(r_len);
            rec_cnt      <= rec_cnt + 1'b1;
            state        <= S_QEND;
          end
        end
        S_STAT: begin
          if (out_load) begin
            record_kind  <= KIND_STATUS;
            data_offset  <= '0;
            ttl_start    <= '0;
            address_high <= '0;
            address_low  <= '0;
            status       <= st_code;
            run_last     <= 1'b1;
            state        <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule
